>>> hw/rtl/pdhs_pkg.sv
// Package for the pair deduplication hash set.
// Holds the sizes, index widths and the pair store entry type.
// Depends on nothing; used by pair_dedup_hash_set.
package pdhs_pkg;

  localparam int unsigned ID_W          = 32;
  localparam int unsigned BUCKET_COUNT  = 1021;
  localparam int unsigned PAIR_CAPACITY = 1024;

  localparam int unsigned BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int unsigned INDEX_W  = $clog2(PAIR_CAPACITY);
  localparam int unsigned COUNT_W  = $clog2(PAIR_CAPACITY + 1);

  // 2**BUCKET_W mod BUCKET_COUNT, used to fold the high part of an identifier.
  localparam int unsigned FOLD_MUL = (1 << BUCKET_W) - BUCKET_COUNT;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef struct packed {
    logic [ID_W-1:0] low_id;
    logic [ID_W-1:0] high_id;
    index_t          link;
    logic            link_valid;
    bucket_t         bucket;
  } pair_entry_t;

endpackage

>>> hw/rtl/pair_dedup_hash_set.sv
// Top level of the pair deduplication hash set: sequencer, fold unit and memories.
// Depends on pdhs_pkg for sizes and the pair store entry type.
// A check folds the lower identifier to a bucket, reads the bucket head and walks the
// chain one entry at a time, ending with a pair found, a new pair inserted, or a pair
// refused when the store is full; a clear only resets the pair count.
// One transaction at a time: req_stall holds off a new request until the last result is
// given; the single pair store read port serves the head entry and every chain entry.
// Reset clears the sequencer, the response valid flag and the pair count; the memories
// are not swept, as the pair count and the bucket kept with each pair mark live heads.
module pair_dedup_hash_set (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic [pdhs_pkg::ID_W-1:0]   id_first,
  input  logic [pdhs_pkg::ID_W-1:0]   id_second,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        already_seen,
  output logic                        store_full
);

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_HASH       = 7'b0000010,
    ST_HEAD_READ  = 7'b0000100,
    ST_ENTRY_READ = 7'b0001000,
    ST_COMPARE    = 7'b0010000,
    ST_INSERT     = 7'b0100000,
    ST_DONE       = 7'b1000000
  } state_t;

  state_t                          state;
  logic [pdhs_pkg::ID_W-1:0]       low_id;
  logic [pdhs_pkg::ID_W-1:0]       high_id;
  logic [pdhs_pkg::ID_W-1:0]       fold;
  logic [pdhs_pkg::ID_W-1:0]       fold_next;
  logic [pdhs_pkg::ID_W-1:0]       fold_high;
  pdhs_pkg::bucket_t               bucket;
  pdhs_pkg::bucket_t               bucket_next;
  pdhs_pkg::count_t                pair_count;
  pdhs_pkg::index_t                cur;
  pdhs_pkg::index_t                rd_addr;
  logic                            first;
  logic                            head_live;
  logic                            res_seen;
  logic                            res_full;
  logic                            entry_live;
  logic                            entry_hit;
  logic                            head_we;
  logic                            pair_we;
  pdhs_pkg::pair_entry_t           wr_entry;

  pdhs_pkg::index_t                head_mem [pdhs_pkg::BUCKET_COUNT];
  pdhs_pkg::index_t                head_rd;
  pdhs_pkg::pair_entry_t           pair_mem [pdhs_pkg::PAIR_CAPACITY];
  pdhs_pkg::pair_entry_t           pair_rd;

  assign req_stall = (state != ST_IDLE);

  assign fold_high = fold >> pdhs_pkg::BUCKET_W;
  assign fold_next = fold_high * pdhs_pkg::ID_W'(pdhs_pkg::FOLD_MUL)
                   + pdhs_pkg::ID_W'(fold[pdhs_pkg::BUCKET_W-1:0]);
  assign bucket_next =
    (fold[pdhs_pkg::BUCKET_W-1:0] >= pdhs_pkg::BUCKET_W'(pdhs_pkg::BUCKET_COUNT)) ?
    fold[pdhs_pkg::BUCKET_W-1:0] - pdhs_pkg::BUCKET_W'(pdhs_pkg::BUCKET_COUNT) :
    fold[pdhs_pkg::BUCKET_W-1:0];

  assign rd_addr = first ? head_rd : cur;

  // The head entry is live only if it lies below the pair count and was written
  // for this bucket since the last clear.
  assign entry_live = first ?
    ((pdhs_pkg::COUNT_W'(cur) < pair_count) && (pair_rd.bucket == bucket)) : 1'b1;
  assign entry_hit  = entry_live && (pair_rd.low_id == low_id) &&
                      (pair_rd.high_id == high_id);

  assign head_we = (state == ST_INSERT) &&
                   (pair_count != pdhs_pkg::COUNT_W'(pdhs_pkg::PAIR_CAPACITY));
  assign pair_we = head_we;

  always_comb begin
    wr_entry.low_id     = low_id;
    wr_entry.high_id    = high_id;
    wr_entry.link       = head_rd;
    wr_entry.link_valid = head_live;
    wr_entry.bucket     = bucket;
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[bucket] <= pair_count[pdhs_pkg::INDEX_W-1:0];
    end
    head_rd <= head_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (pair_we) begin
      pair_mem[pair_count[pdhs_pkg::INDEX_W-1:0]] <= wr_entry;
    end
    pair_rd <= pair_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_count <= '0;
      rsp_valid  <= 1'b0;
      first      <= 1'b0;
    end else begin
      if ((state != ST_DONE) && rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            res_seen <= 1'b0;
            res_full <= 1'b0;
            if (req_type == pdhs_pkg::REQ_CLEAR) begin
              pair_count <= '0;
              state      <= ST_DONE;
            end else begin
              low_id  <= (id_first < id_second) ? id_first : id_second;
              high_id <= (id_first < id_second) ? id_second : id_first;
              fold    <= (id_first < id_second) ? id_first : id_second;
              state   <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (|fold_high) begin
            fold <= fold_next;
          end else begin
            bucket <= bucket_next;
            state  <= ST_HEAD_READ;
          end
        end
        ST_HEAD_READ: begin
          first <= 1'b1;
          state <= ST_ENTRY_READ;
        end
        ST_ENTRY_READ: begin
          cur   <= rd_addr;
          state <= ST_COMPARE;
        end
        ST_COMPARE: begin
          if (entry_hit) begin
            res_seen <= 1'b1;
            state    <= ST_DONE;
          end else if (entry_live && pair_rd.link_valid) begin
            cur   <= pair_rd.link;
            first <= 1'b0;
            state <= ST_ENTRY_READ;
          end else begin
            if (entry_live) begin
              head_live <= 1'b1;
            end else begin
              head_live <= 1'b0;
            end
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (head_we) begin
            pair_count <= pair_count + pdhs_pkg::COUNT_W'(1);
          end else begin
            res_full <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            already_seen <= res_seen;
            store_full   <= res_full;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    pair_count <= pdhs_pkg::COUNT_W'(pdhs_pkg::PAIR_CAPACITY))
    else $error("pair count exceeds the store capacity");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (pair_count != $past(pair_count)) |->
      ((pair_count == $past(pair_count) + pdhs_pkg::COUNT_W'(1)) || (pair_count == '0)))
    else $error("pair count moved other than by one insertion or a clear");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(already_seen && store_full))
    else $error("result reports a pair both seen and not stored");

  a_chain_in_store: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMPARE) && !first) |-> (pdhs_pkg::COUNT_W'(cur) < pair_count))
    else $error("chain walk left the written part of the pair store");
`endif

endmodule
